/* hdl/cia_pkg.sv */
// Shared types, operation codes and overflow policy helper for the checked integer ALU.
// No dependencies; used by every module of the block.
package cia_pkg;

    localparam int DataW = 64;
    localparam int DivStages = DataW;

    localparam logic [DataW-1:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DataW-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DataW-1:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [DataW-1:0] CMP_ONE = 64'h0000_0000_0000_0001;

    localparam logic [4:0] MODE_SADD   = 5'd0;
    localparam logic [4:0] MODE_SSUB   = 5'd1;
    localparam logic [4:0] MODE_SMUL   = 5'd2;
    localparam logic [4:0] MODE_UADD   = 5'd3;
    localparam logic [4:0] MODE_USUB   = 5'd4;
    localparam logic [4:0] MODE_UMUL   = 5'd5;
    localparam logic [4:0] MODE_SDIV   = 5'd6;
    localparam logic [4:0] MODE_UDIV   = 5'd7;
    localparam logic [4:0] MODE_SREM   = 5'd8;
    localparam logic [4:0] MODE_UREM   = 5'd9;
    localparam logic [4:0] MODE_SCMP   = 5'd10;
    localparam logic [4:0] MODE_UCMP   = 5'd11;
    localparam logic [4:0] MODE_STOU   = 5'd12;
    localparam logic [4:0] MODE_UTOS   = 5'd13;
    localparam logic [4:0] MODE_SABS   = 5'd14;
    localparam logic [4:0] MODE_UABS   = 5'd15;
    localparam logic [4:0] MODE_SRANGE = 5'd16;
    localparam logic [4:0] MODE_URANGE = 5'd17;

    localparam logic [1:0] POL_FLAG = 2'd0;
    localparam logic [1:0] POL_WRAP = 2'd1;
    localparam logic [1:0] POL_SAT  = 2'd2;
    localparam logic [1:0] POL_TRAP = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    localparam logic [1:0] RW_8  = 2'd0;
    localparam logic [1:0] RW_16 = 2'd1;
    localparam logic [1:0] RW_32 = 2'd2;
    localparam logic [1:0] RW_64 = 2'd3;

    typedef enum logic [1:0] {
        DSEL_NONE,
        DSEL_QUOT,
        DSEL_REM
    } dsel_t;

    typedef struct packed {
        logic [DataW-1:0] val;
        logic             ovf;
        logic [1:0]       err;
    } res_t;

    typedef struct packed {
        res_t  res;
        dsel_t dsel;
        logic  negr;
    } side_t;

    function automatic res_t apply_policy(input logic [1:0] pol, input logic [DataW-1:0] wrapped,
                                          input logic ovf, input logic [DataW-1:0] satv);
        res_t r;
        r.val = wrapped;
        r.ovf = 1'b0;
        r.err = ERR_NONE;
        if (ovf)
        begin
            case (pol)
                POL_FLAG: r.ovf = 1'b1;
                POL_WRAP: r.val = wrapped;
                POL_SAT:  r.val = satv;
                default:
                begin
                    r.val = '0;
                    r.err = ERR_OVF;
                end
            endcase
        end
        return r;
    endfunction

endpackage

/* hdl/checked_integer_alu.sv */
// Checked 64-bit integer ALU with flag, wrap, saturate and trap overflow policies.
// Depends on cia_pkg and cia_div (pipelined divider).
//
// Every transaction passes through the same 70 register stages: input register, operand
// preparation, 32x32 partial products, product assembly, multiply overflow policy, 64
// one-bit divider stages, and the output register. One transaction is accepted per cycle
// while the output is not stalled. A stall on a valid output freezes the whole pipeline,
// and in_stall follows it in the same cycle.
module checked_integer_alu
    import cia_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [4:0]       mode,
    input  logic [1:0]       overflow_policy,
    input  logic [DataW-1:0] lhs,
    input  logic [DataW-1:0] rhs,
    input  logic [1:0]       range_width,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [DataW-1:0] result,
    output logic             overflowed,
    output logic [1:0]       error_code
);

    typedef struct packed {
        logic [4:0] mode;
        logic [1:0] pol;
        logic       negp;
        dsel_t      dsel;
        logic       negr;
        res_t       res;
    } ctl_t;

    logic adv;

    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic [4:0]       mode1_reg;
    logic [1:0]       pol1_reg;
    logic [1:0]       rw1_reg;
    logic [DataW-1:0] a1_reg, b1_reg;

    ctl_t             ctl2_reg, ctl3_reg, ctl4_reg, ctl2_next;
    logic [DataW-1:0] ma2_reg, mb2_reg, ma3_reg, mb3_reg, ma4_reg, mb4_reg;
    logic [DataW-1:0] ma2_next, mb2_next;
    logic [DataW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [DataW-1:0] hi_next, lo_next;
    logic [33:0]      mid;
    logic [DataW-1:0] hi4_reg, lo4_reg;

    side_t            side5_reg, side5_next;
    logic [DataW-1:0] ma5_reg, mb5_reg;

    logic             dv_vld;
    side_t            dv_side;
    logic [DataW-1:0] dv_quot, dv_rem;

    logic [DataW-1:0] res_reg;
    logic             ovf_reg;
    logic [1:0]       err_reg;
    res_t             out_next;

    assign adv      = !(vo_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vo_reg <= dv_vld;
        end
    end

    always_comb
    begin
        logic             an, bn, sgn;
        logic [DataW:0]   sum, dif;
        logic             ult, slt, eq;
        logic [DataW-1:0] cmpv, nega, negb, ah;
        an   = a1_reg[DataW-1];
        bn   = b1_reg[DataW-1];
        sum  = {1'b0, a1_reg} + {1'b0, b1_reg};
        dif  = {1'b0, a1_reg} - {1'b0, b1_reg};
        ult  = dif[DataW];
        eq   = (a1_reg == b1_reg);
        slt  = (an != bn) ? an : ult;
        nega = '0 - a1_reg;
        negb = '0 - b1_reg;
        sgn  = (mode1_reg == MODE_SMUL) || (mode1_reg == MODE_SDIV) || (mode1_reg == MODE_SREM);
        ah   = '0;
        cmpv = '0;

        ctl2_next.mode = mode1_reg;
        ctl2_next.pol  = pol1_reg;
        ctl2_next.negp = an ^ bn;
        ctl2_next.dsel = DSEL_NONE;
        ctl2_next.negr = 1'b0;
        ctl2_next.res  = '0;
        ma2_next = (sgn && an) ? nega : a1_reg;
        mb2_next = (sgn && bn) ? negb : b1_reg;

        case (mode1_reg)
            MODE_SADD:
                ctl2_next.res = apply_policy(pol1_reg, sum[DataW-1:0],
                    (an == bn) && (sum[DataW-1] != an), bn ? S64_MIN : S64_MAX);
            MODE_SSUB:
                ctl2_next.res = apply_policy(pol1_reg, dif[DataW-1:0],
                    (an != bn) && (dif[DataW-1] != an), bn ? S64_MAX : S64_MIN);
            MODE_UADD:
                ctl2_next.res = apply_policy(pol1_reg, sum[DataW-1:0], sum[DataW], U64_MAX);
            MODE_USUB:
                ctl2_next.res = apply_policy(pol1_reg, dif[DataW-1:0], ult, '0);
            MODE_SDIV, MODE_UDIV, MODE_SREM, MODE_UREM:
            begin
                if (b1_reg == '0)
                begin
                    ctl2_next.res.err = ERR_DIV0;
                end
                else if (mode1_reg == MODE_SDIV && a1_reg == S64_MIN && b1_reg == U64_MAX)
                begin
                    ctl2_next.res = apply_policy(pol1_reg, S64_MIN, 1'b1, S64_MAX);
                end
                else
                begin
                    ctl2_next.dsel = (mode1_reg == MODE_SDIV || mode1_reg == MODE_UDIV)
                                     ? DSEL_QUOT : DSEL_REM;
                    ctl2_next.negr = (mode1_reg == MODE_SDIV) ? (an ^ bn)
                                   : (mode1_reg == MODE_SREM) ? an : 1'b0;
                end
            end
            MODE_SCMP:
            begin
                cmpv = eq ? '0 : (slt ? U64_MAX : CMP_ONE);
                ctl2_next.res.val = cmpv;
            end
            MODE_UCMP:
            begin
                cmpv = eq ? '0 : (ult ? U64_MAX : CMP_ONE);
                ctl2_next.res.val = cmpv;
            end
            MODE_STOU:
                ctl2_next.res = apply_policy(pol1_reg, a1_reg, an, '0);
            MODE_UTOS:
                ctl2_next.res = apply_policy(pol1_reg, a1_reg, an, S64_MAX);
            MODE_SABS:
            begin
                if (a1_reg == S64_MIN)
                    ctl2_next.res = apply_policy(pol1_reg, S64_MIN, 1'b1, S64_MAX);
                else
                    ctl2_next.res.val = an ? nega : a1_reg;
            end
            MODE_UABS:
                ctl2_next.res.val = an ? nega : a1_reg;
            MODE_SRANGE:
            begin
                ctl2_next.res.val = a1_reg;
                case (rw1_reg)
                    RW_8:  ah = a1_reg + 64'd128;
                    RW_16: ah = a1_reg + 64'd32768;
                    RW_32: ah = a1_reg + 64'h8000_0000;
                    default: ah = '0;
                endcase
                case (rw1_reg)
                    RW_8:  ctl2_next.res.ovf = |ah[DataW-1:8];
                    RW_16: ctl2_next.res.ovf = |ah[DataW-1:16];
                    RW_32: ctl2_next.res.ovf = |ah[DataW-1:32];
                    default: ctl2_next.res.ovf = 1'b0;
                endcase
            end
            MODE_URANGE:
            begin
                ctl2_next.res.val = a1_reg;
                case (rw1_reg)
                    RW_8:  ctl2_next.res.ovf = |a1_reg[DataW-1:8];
                    RW_16: ctl2_next.res.ovf = |a1_reg[DataW-1:16];
                    RW_32: ctl2_next.res.ovf = |a1_reg[DataW-1:32];
                    default: ctl2_next.res.ovf = 1'b0;
                endcase
            end
            default:
                ctl2_next.res = '0;
        endcase
    end

    always_comb
    begin
        mid = {2'b0, p00_reg[63:32]} + {2'b0, p01_reg[31:0]} + {2'b0, p10_reg[31:0]};
        lo_next = {mid[31:0], p00_reg[31:0]};
        hi_next = p11_reg + {32'b0, p01_reg[63:32]} + {32'b0, p10_reg[63:32]}
                + {62'b0, mid[33:32]};
    end

    always_comb
    begin
        logic [DataW-1:0] lo_raw;
        logic             movf;
        lo_raw = ctl4_reg.negp ? ('0 - lo4_reg) : lo4_reg;
        movf   = (hi4_reg != '0) ||
                 (ctl4_reg.negp ? (lo4_reg > S64_MIN) : (lo4_reg > S64_MAX));
        side5_next.res  = ctl4_reg.res;
        side5_next.dsel = ctl4_reg.dsel;
        side5_next.negr = ctl4_reg.negr;
        if (ctl4_reg.mode == MODE_SMUL)
            side5_next.res = apply_policy(ctl4_reg.pol, lo_raw, movf,
                                          ctl4_reg.negp ? S64_MIN : S64_MAX);
        else if (ctl4_reg.mode == MODE_UMUL)
            side5_next.res = apply_policy(ctl4_reg.pol, lo4_reg, hi4_reg != '0, U64_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= mode;
            pol1_reg  <= overflow_policy;
            rw1_reg   <= range_width;
            a1_reg    <= lhs;
            b1_reg    <= rhs;
            ctl2_reg  <= ctl2_next;
            ma2_reg   <= ma2_next;
            mb2_reg   <= mb2_next;
            ctl3_reg  <= ctl2_reg;
            ma3_reg   <= ma2_reg;
            mb3_reg   <= mb2_reg;
            p00_reg   <= {32'b0, ma2_reg[31:0]}  * {32'b0, mb2_reg[31:0]};
            p01_reg   <= {32'b0, ma2_reg[31:0]}  * {32'b0, mb2_reg[63:32]};
            p10_reg   <= {32'b0, ma2_reg[63:32]} * {32'b0, mb2_reg[31:0]};
            p11_reg   <= {32'b0, ma2_reg[63:32]} * {32'b0, mb2_reg[63:32]};
            ctl4_reg  <= ctl3_reg;
            ma4_reg   <= ma3_reg;
            mb4_reg   <= mb3_reg;
            hi4_reg   <= hi_next;
            lo4_reg   <= lo_next;
            side5_reg <= side5_next;
            ma5_reg   <= ma4_reg;
            mb5_reg   <= mb4_reg;
            res_reg   <= out_next.val;
            ovf_reg   <= out_next.ovf;
            err_reg   <= out_next.err;
        end
    end

    cia_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (v5_reg),
        .in_side  (side5_reg),
        .dividend (ma5_reg),
        .divisor  (mb5_reg),
        .out_vld  (dv_vld),
        .out_side (dv_side),
        .quot     (dv_quot),
        .rem      (dv_rem)
    );

    always_comb
    begin
        logic [DataW-1:0] dv;
        dv = (dv_side.dsel == DSEL_QUOT) ? dv_quot : dv_rem;
        out_next = dv_side.res;
        if (dv_side.dsel != DSEL_NONE)
        begin
            out_next.val = dv_side.negr ? ('0 - dv) : dv;
            out_next.ovf = 1'b0;
            out_next.err = ERR_NONE;
        end
    end

    assign out_valid  = vo_reg;
    assign result     = res_reg;
    assign overflowed = ovf_reg;
    assign error_code = err_reg;

endmodule

/* hdl/cia_div.sv */
// Pipelined restoring divider for the checked integer ALU: one quotient bit per stage.
// Depends on cia_pkg; carries a side_t sideband alongside each transaction.
module cia_div
    import cia_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  side_t            in_side,
    input  logic [DataW-1:0] dividend,
    input  logic [DataW-1:0] divisor,
    output logic             out_vld,
    output side_t            out_side,
    output logic [DataW-1:0] quot,
    output logic [DataW-1:0] rem
);

    logic             vld_reg  [DivStages];
    side_t            side_reg [DivStages];
    logic [DataW-1:0] rem_reg  [DivStages];
    logic [DataW-1:0] q_reg    [DivStages];
    logic [DataW-1:0] d_reg    [DivStages];

    genvar i;
    generate
        for (i = 0; i < DivStages; i++)
        begin : g_stage
            logic             vld_in;
            side_t            side_in;
            logic [DataW-1:0] rem_in;
            logic [DataW-1:0] q_in;
            logic [DataW-1:0] d_in;
            logic [DataW:0]   trial;
            logic [DataW:0]   diff;
            logic [DataW-1:0] rem_next;
            logic [DataW-1:0] q_next;

            if (i == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign side_in = in_side;
                assign rem_in  = '0;
                assign q_in    = dividend;
                assign d_in    = divisor;
            end
            else
            begin : g_rest
                assign vld_in  = vld_reg[i-1];
                assign side_in = side_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign q_in    = q_reg[i-1];
                assign d_in    = d_reg[i-1];
            end

            always_comb
            begin
                trial = {rem_in, q_in[DataW-1]};
                diff  = trial - {1'b0, d_in};
                if (!diff[DataW])
                begin
                    rem_next = diff[DataW-1:0];
                    q_next   = {q_in[DataW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DataW-1:0];
                    q_next   = {q_in[DataW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (adv)
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[i] <= side_in;
                    rem_reg[i]  <= rem_next;
                    q_reg[i]    <= q_next;
                    d_reg[i]    <= d_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DivStages-1];
    assign out_side = side_reg[DivStages-1];
    assign quot     = q_reg[DivStages-1];
    assign rem      = rem_reg[DivStages-1];

endmodule

/* hdl/cia_checker.sv */
// Port-level assertions for the checked integer ALU, attached by bind.
// Depends on cia_pkg and the top-level ports of checked_integer_alu.
module cia_checker
    import cia_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [DataW-1:0] result,
    input logic             overflowed,
    input logic [1:0]       error_code
);

    a_stall_follow: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> result == '0 && !overflowed)
        else $error("error transaction carries value or flag");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_code == ERR_NONE || error_code == ERR_DIV0 || error_code == ERR_OVF)
        else $error("undefined error code");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result) && $stable(error_code))
        else $error("stalled result changed");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result),
    .overflowed (overflowed),
    .error_code (error_code)
);

/* tb/tb_checked_integer_alu.sv */
// Self-checking testbench for checked_integer_alu: directed and random transactions,
// predicted results compared against the block output in order.
// Depends on cia_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_checked_integer_alu;
    import cia_pkg::*;

    typedef struct packed {
        logic [4:0]  mode;
        logic [1:0]  pol;
        logic [63:0] a;
        logic [63:0] b;
        logic [1:0]  rw;
    } op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [4:0] mode = '0;
    logic [1:0] overflow_policy = '0;
    logic [63:0] lhs = '0;
    logic [63:0] rhs = '0;
    logic [1:0] range_width = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [63:0] result;
    logic overflowed;
    logic [1:0] error_code;

    op_t pending_ops[$];
    res_t expected_res[$];
    int fail_count = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;
    bit in_held = 1'b0;
    int gap_left = 0;
    int stall_left = 0;

    checked_integer_alu i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .overflow_policy(overflow_policy), .lhs(lhs), .rhs(rhs),
        .range_width(range_width), .out_valid(out_valid), .out_stall(out_stall),
        .result(result), .overflowed(overflowed), .error_code(error_code)
    );

    always #5 clk = ~clk;

    function automatic res_t policy_res(logic [1:0] pol, logic [63:0] w, bit ovf,
                                        logic [63:0] satv);
        res_t r;
        r.val = w;
        r.ovf = 1'b0;
        r.err = ERR_NONE;
        if (ovf)
        begin
            if (pol == POL_FLAG)
                r.ovf = 1'b1;
            else if (pol == POL_SAT)
                r.val = satv;
            else if (pol == POL_TRAP)
            begin
                r.val = '0;
                r.err = ERR_OVF;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] x);
        return x[63] ? -x : x;
    endfunction

    function automatic logic [63:0] order3(logic [63:0] x, logic [63:0] y);
        if (x > y)
            return CMP_ONE;
        if (x < y)
            return U64_MAX;
        return '0;
    endfunction

    function automatic res_t alu_predict(op_t t);
        res_t r;
        logic [63:0] s;
        logic [127:0] p;
        bit an;
        bit bn;
        bit ng;
        int w;
        an = t.a[63];
        bn = t.b[63];
        r = '0;
        case (t.mode)
            MODE_SADD:
            begin
                s = t.a + t.b;
                r = policy_res(t.pol, s, an == bn && s[63] != an, bn ? S64_MIN : S64_MAX);
            end
            MODE_SSUB:
            begin
                s = t.a - t.b;
                r = policy_res(t.pol, s, an != bn && s[63] != an, bn ? S64_MAX : S64_MIN);
            end
            MODE_SMUL:
            begin
                ng = an != bn;
                p = {64'd0, magnitude(t.a)} * {64'd0, magnitude(t.b)};
                r = policy_res(t.pol, t.a * t.b,
                    p[127:64] != 0 || (ng ? p[63:0] > S64_MIN : p[63:0] > S64_MAX),
                    ng ? S64_MIN : S64_MAX);
            end
            MODE_UADD:
            begin
                s = t.a + t.b;
                r = policy_res(t.pol, s, s < t.a, U64_MAX);
            end
            MODE_USUB: r = policy_res(t.pol, t.a - t.b, t.b > t.a, '0);
            MODE_UMUL:
            begin
                p = {64'd0, t.a} * {64'd0, t.b};
                r = policy_res(t.pol, p[63:0], p[127:64] != 0, U64_MAX);
            end
            MODE_SDIV:
                if (t.b == 0)
                    r.err = ERR_DIV0;
                else if (t.a == S64_MIN && t.b == U64_MAX)
                    r = policy_res(t.pol, S64_MIN, 1'b1, S64_MAX);
                else
                begin
                    s = magnitude(t.a) / magnitude(t.b);
                    r.val = (an != bn) ? -s : s;
                end
            MODE_UDIV:
                if (t.b == 0)
                    r.err = ERR_DIV0;
                else
                    r.val = t.a / t.b;
            MODE_SREM:
                if (t.b == 0)
                    r.err = ERR_DIV0;
                else
                begin
                    s = magnitude(t.a) % magnitude(t.b);
                    r.val = an ? -s : s;
                end
            MODE_UREM:
                if (t.b == 0)
                    r.err = ERR_DIV0;
                else
                    r.val = t.a % t.b;
            MODE_SCMP: r.val = order3(t.a ^ S64_MIN, t.b ^ S64_MIN);
            MODE_UCMP: r.val = order3(t.a, t.b);
            MODE_STOU: r = policy_res(t.pol, t.a, an, '0);
            MODE_UTOS: r = policy_res(t.pol, t.a, an, S64_MAX);
            MODE_SABS:
                if (t.a == S64_MIN)
                    r = policy_res(t.pol, S64_MIN, 1'b1, S64_MAX);
                else
                    r.val = magnitude(t.a);
            MODE_UABS: r.val = magnitude(t.a);
            MODE_SRANGE:
            begin
                r.val = t.a;
                if (t.rw != RW_64)
                begin
                    w = 8 << t.rw;
                    s = t.a + (64'd1 << (w - 1));
                    r.ovf = (s >> w) != 0;
                end
            end
            MODE_URANGE:
            begin
                r.val = t.a;
                if (t.rw != RW_64)
                begin
                    w = 8 << t.rw;
                    r.ovf = (t.a >> w) != 0;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        int k;
        v = {$urandom, $urandom};
        k = $urandom_range(0, 11);
        case (k)
            0: v = '0;
            1: v = S64_MIN;
            2: v = S64_MAX;
            3: v = U64_MAX;
            4: v = 64'd1;
            5: v = {{56{v[7]}}, v[7:0]};
            6: v = {{48{v[15]}}, v[15:0]};
            7: v = {{32{v[31]}}, v[31:0]};
            8: v = {32'd0, v[31:0]};
            9: v = v >> $urandom_range(1, 63);
            default: ;
        endcase
        return v;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    endfunction

    task automatic add_op(logic [4:0] m, logic [1:0] p, logic [63:0] a, logic [63:0] b,
                          logic [1:0] w);
        op_t t;
        t.mode = m;
        t.pol = p;
        t.a = a;
        t.b = b;
        t.rw = w;
        pending_ops.push_back(t);
    endtask

    initial
    begin
        op_t t;
        add_op(MODE_SADD, POL_FLAG, S64_MAX, 64'd1, RW_8);
        add_op(MODE_SADD, POL_SAT, S64_MIN, U64_MAX, RW_8);
        add_op(MODE_SSUB, POL_TRAP, S64_MIN, 64'd1, RW_8);
        add_op(MODE_SMUL, POL_SAT, S64_MAX, 64'd2, RW_8);
        add_op(MODE_SMUL, POL_FLAG, S64_MIN, 64'd1, RW_8);
        add_op(MODE_UADD, POL_SAT, U64_MAX, 64'd1, RW_8);
        add_op(MODE_USUB, POL_SAT, 64'd0, 64'd1, RW_8);
        add_op(MODE_UMUL, POL_TRAP, U64_MAX, U64_MAX, RW_8);
        add_op(MODE_SDIV, POL_FLAG, S64_MIN, U64_MAX, RW_8);
        add_op(MODE_SDIV, POL_WRAP, S64_MIN, U64_MAX, RW_8);
        add_op(MODE_SDIV, POL_SAT, S64_MIN, U64_MAX, RW_8);
        add_op(MODE_SDIV, POL_TRAP, S64_MIN, U64_MAX, RW_8);
        add_op(MODE_UDIV, POL_WRAP, 64'd5, 64'd0, RW_8);
        add_op(MODE_SREM, POL_FLAG, S64_MIN, U64_MAX, RW_8);
        add_op(MODE_UREM, POL_FLAG, U64_MAX, 64'd0, RW_8);
        add_op(MODE_SCMP, POL_FLAG, S64_MIN, S64_MAX, RW_8);
        add_op(MODE_UCMP, POL_FLAG, S64_MIN, S64_MAX, RW_8);
        add_op(MODE_STOU, POL_SAT, U64_MAX, 64'd0, RW_8);
        add_op(MODE_UTOS, POL_SAT, U64_MAX, 64'd0, RW_8);
        add_op(MODE_SABS, POL_TRAP, S64_MIN, 64'd0, RW_8);
        add_op(MODE_UABS, POL_FLAG, S64_MIN, 64'd0, RW_8);
        add_op(MODE_SRANGE, POL_FLAG, 64'hFFFF_FFFF_FFFF_FF80, 64'd0, RW_8);
        add_op(MODE_SRANGE, POL_FLAG, 64'h0000_0000_0000_8000, 64'd0, RW_16);
        add_op(MODE_URANGE, POL_FLAG, 64'h0000_0001_0000_0000, 64'd0, RW_32);
        add_op(5'd31, POL_TRAP, U64_MAX, U64_MAX, RW_64);
        repeat (950)
        begin
            t.mode = ($urandom_range(0, 29) == 0) ? 5'($urandom_range(18, 31))
                                                  : 5'($urandom_range(0, 17));
            t.pol = 2'($urandom);
            t.a = pick_operand();
            t.b = pick_operand();
            t.rw = 2'($urandom);
            pending_ops.push_back(t);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // hold off the receiver for a long stretch to back up the pipeline
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(negedge clk)
    begin
        op_t t;
        if (rst_n && !in_held)
        begin
            if (in_valid)
                gap_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (gap_left > 0 || pending_ops.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
                if (pending_ops.size() == 0)
                    stim_done = 1'b1;
            end
            else
            begin
                t = pending_ops.pop_front();
                in_valid <= 1'b1;
                mode <= t.mode;
                overflow_policy <= t.pol;
                lhs <= t.a;
                rhs <= t.b;
                range_width <= t.rw;
            end
        end
        if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 3) == 0)
            stall_left = gap_len();
        out_stall <= hold_off || stall_left > 0;
    end

    always @(posedge clk)
    begin
        op_t t;
        res_t e;
        in_held = in_valid && in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            t.mode = mode;
            t.pol = overflow_policy;
            t.a = lhs;
            t.b = rhs;
            t.rw = range_width;
            expected_res.push_back(alu_predict(t));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_res.size() == 0)
            begin
                $error("unexpected result %h", result);
                fail_count++;
            end
            else
            begin
                e = expected_res.pop_front();
                if (result !== e.val)
                begin
                    $error("result: expected %h actual %h", e.val, result);
                    fail_count++;
                end
                if (overflowed !== e.ovf)
                begin
                    $error("overflowed: expected %b actual %b", e.ovf, overflowed);
                    fail_count++;
                end
                if (error_code !== e.err)
                begin
                    $error("error_code: expected %0d actual %0d", e.err, error_code);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done && !in_valid);
        wait (expected_res.size() == 0);
        repeat (150) @(posedge clk);
        if (fail_count == 0 && expected_res.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/cia_pkg.sv
hdl/cia_div.sv
hdl/checked_integer_alu.sv
hdl/cia_checker.sv
tb/tb_checked_integer_alu.sv
